// ----- sv/palf_pkg.sv -----
// Package for the lowest-free page allocator.
// Command, status and controller state codes plus stream field widths.
// Used by page_allocator_lowest_free_unit; depends on nothing.
package palf_pkg;

  // stream payload widths
  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 80;
  localparam int unsigned PAGE_W     = 10;
  localparam int unsigned TAG_W      = 64;

  // bitmap word geometry: 32 pages per word
  localparam int unsigned WORD_PAGES = 32;

  typedef enum logic [2:0] {
    CMD_ALLOC   = 3'd0,
    CMD_FREE    = 3'd1,
    CMD_QUERY   = 3'd2,
    CMD_GET_TAG = 3'd3,
    CMD_SET_TAG = 3'd4,
    CMD_RESTORE = 3'd5,
    CMD_MARK    = 3'd6,
    CMD_EXTEND  = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_RANGE        = 3'd1,
    ST_ALREADY_FREE = 3'd2,
    ST_NOT_FREE     = 3'd3,
    ST_FULL         = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_MOD,
    S_DONE
  } state_t;

endpackage

// ----- sv/page_allocator_lowest_free_unit.sv -----
// Lowest-free-first page allocator over a bitmap memory and a tag memory.
// Depends on palf_pkg for command/status/state codes and widths.
//
//  channel | dir | beat fields (tdata, lowest bit first)
//  s_axis  | in  | command[3], page_number[10], tag_value[64], tag_given, mark_allocated
//  m_axis  | out | status[3], result_page[10], page_in_use, tag_out[64], tag_present
//
// A beat is taken in S_IDLE, then a read (S_RD), a modify/write (S_MOD) and an
// output load (S_DONE) of a 64-bit bitmap word (free bits low, tag-present bits
// high). Allocate at a full pool and an extend beyond the pool skip the memory
// and go straight to S_DONE. Allocate with free pages scans words from page 0
// and extend walks words from the count up to the target, with S_RD and S_MOD per extra word.
// No clearing pass after reset: pages enter the bitmap as the count grows. The
// output register lets the next beat in while a result waits for m_axis_tready;
// the load cycle holds until that register is free.
module page_allocator_lowest_free_unit #(
  parameter int unsigned POOL_PAGES = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // command, page_number, tag_value, tag_given, mark_allocated, zero pad
  input  logic [palf_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // status, result_page, page_in_use, tag_out, tag_present, zero pad
  output logic [palf_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  localparam int unsigned NW = (POOL_PAGES + palf_pkg::WORD_PAGES - 1) / palf_pkg::WORD_PAGES;
  localparam int unsigned WW = (NW > 1) ? $clog2(NW) : 1;
  localparam int unsigned CW = $clog2(POOL_PAGES + 1);
  localparam int unsigned TW = $clog2(POOL_PAGES);

  palf_pkg::state_t state, state_next;

  // latched command
  palf_pkg::cmd_t                cmd;
  logic [palf_pkg::PAGE_W-1:0]   pg;
  logic [palf_pkg::TAG_W-1:0]    tval;
  logic                          tgiven;
  logic                          mark;
  logic                          grow;
  logic [WW-1:0]                 wa;

  logic [CW-1:0] cnt;
  logic [CW-1:0] nfree;

  // pending result and output register
  palf_pkg::status_t             res_status;
  logic [palf_pkg::PAGE_W-1:0]   res_page;
  logic                          res_isa;
  logic [palf_pkg::TAG_W-1:0]    res_tag;
  logic                          res_pres;
  logic                          out_valid;
  logic [palf_pkg::OUT_DATA_W-1:0] out_data;

  // memories
  logic [63:0]                 wmem [NW];
  logic [palf_pkg::TAG_W-1:0]  tmem [POOL_PAGES];
  logic [63:0]                 wd;
  logic [palf_pkg::TAG_W-1:0]  td;

  // input beat fields
  logic                        in_fire;
  palf_pkg::cmd_t              in_cmd;
  logic [palf_pkg::PAGE_W-1:0] in_pg;
  logic [31:0]                 in_pg32;
  logic                        in_full;
  logic                        in_ext_bad;

  // modify-stage helpers
  logic [31:0] pg32, cnt32, cntw32, pgw32, wa32;
  logic [4:0]  bp;
  logic [TW-1:0] ti;
  logic        inrange;
  logic        alloc_ok;
  logic [31:0] fr, vl, smask, avail, emask;
  logic [4:0]  low;
  logic        clr_en;

  // modify-stage results
  logic                        mod_done;
  logic                        we, te;
  logic [63:0]                 wnew;
  logic [CW-1:0]               cnt_mod, nfree_mod;
  logic [WW-1:0]               wa_mod;
  palf_pkg::status_t           st_mod;
  logic [palf_pkg::PAGE_W-1:0] page_mod;
  logic                        isa_mod, pres_mod;
  logic [palf_pkg::TAG_W-1:0]  tag_mod;

  assign s_axis_tready = (state == palf_pkg::S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_cmd        = palf_pkg::cmd_t'(s_axis_tdata[2:0]);
  assign in_pg         = s_axis_tdata[12:3];
  assign in_pg32       = {22'd0, in_pg};
  assign in_full       = (nfree == '0) && (32'(cnt) >= POOL_PAGES);
  assign in_ext_bad    = (in_pg32 >= POOL_PAGES);

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // address and compare helpers
  assign pg32    = {22'd0, pg};
  assign cnt32   = 32'(cnt);
  assign cntw32  = cnt32 >> 5;
  assign pgw32   = pg32 >> 5;
  assign wa32    = 32'(wa);
  assign bp      = pg32[4:0];
  assign ti      = pg32[TW-1:0];
  assign inrange = (pg32 < cnt32);
  assign fr      = wd[31:0];
  assign vl      = wd[63:32];
  assign alloc_ok = inrange && !fr[bp];
  assign clr_en  = (pg32 >= cnt32);

  // free bits of this word that lie below the count
  always_comb begin
    if (wa32 < cntw32) begin
      smask = '1;
    end else if (wa32 == cntw32) begin
      smask = (32'd1 << cnt32[4:0]) - 32'd1;
    end else begin
      smask = '0;
    end
  end
  assign avail = fr & smask;

  // lowest free bit
  always_comb begin
    low = '0;
    for (int i = 31; i >= 0; i--) begin
      if (avail[i]) low = 5'(i);
    end
  end

  // bits newly covered by an extend walk: count <= page index <= target
  always_comb begin
    for (int i = 0; i < 32; i++) begin
      emask[i] = clr_en && ((wa32 > cntw32) || (5'(i) >= cnt32[4:0]))
                 && ((wa32 < pgw32) || (5'(i) <= bp));
    end
  end

  // modify stage: per command decision and write-back data
  always_comb begin
    mod_done  = 1'b1;
    we        = 1'b0;
    te        = 1'b0;
    wnew      = wd;
    cnt_mod   = cnt;
    nfree_mod = nfree;
    wa_mod    = wa;
    st_mod    = palf_pkg::ST_OK;
    page_mod  = pg;
    isa_mod   = 1'b0;
    pres_mod  = 1'b0;
    tag_mod   = '0;
    unique case (cmd)
      palf_pkg::CMD_ALLOC: begin
        if (grow) begin
          we              = 1'b1;
          wnew[cnt32[4:0]]      = 1'b0;
          wnew[32 + cnt32[4:0]] = 1'b0;
          cnt_mod         = cnt + 1'b1;
          page_mod        = cnt32[9:0];
        end else if (avail != '0) begin
          we              = 1'b1;
          wnew[low]       = 1'b0;
          wnew[32 + low]  = 1'b0;
          nfree_mod       = nfree - 1'b1;
          page_mod        = 10'({wa32[26:0], low});
        end else begin
          mod_done = 1'b0;
          wa_mod   = wa + 1'b1;
        end
      end
      palf_pkg::CMD_FREE: begin
        if (!inrange) begin
          st_mod = palf_pkg::ST_RANGE;
        end else if (fr[bp]) begin
          st_mod = palf_pkg::ST_ALREADY_FREE;
        end else begin
          we        = 1'b1;
          wnew[bp]  = 1'b1;
          nfree_mod = nfree + 1'b1;
        end
      end
      palf_pkg::CMD_QUERY: begin
        isa_mod = alloc_ok;
      end
      palf_pkg::CMD_GET_TAG: begin
        if (!alloc_ok) begin
          st_mod = palf_pkg::ST_RANGE;
        end else begin
          pres_mod = vl[bp];
          tag_mod  = vl[bp] ? td : '0;
        end
      end
      palf_pkg::CMD_SET_TAG: begin
        if (!alloc_ok) begin
          st_mod = palf_pkg::ST_RANGE;
        end else begin
          we            = 1'b1;
          te            = 1'b1;
          wnew[32 + bp] = 1'b1;
        end
      end
      palf_pkg::CMD_RESTORE: begin
        if (inrange && fr[bp]) begin
          we        = 1'b1;
          wnew[bp]  = 1'b0;
          nfree_mod = nfree - 1'b1;
        end else begin
          st_mod = palf_pkg::ST_NOT_FREE;
        end
      end
      palf_pkg::CMD_MARK: begin
        if (!inrange) begin
          st_mod = palf_pkg::ST_RANGE;
        end else begin
          we       = 1'b1;
          wnew[bp] = !mark;
          if (fr[bp] && mark) nfree_mod = nfree - 1'b1;
          else if (!fr[bp] && !mark) nfree_mod = nfree + 1'b1;
        end
      end
      palf_pkg::CMD_EXTEND: begin
        we   = 1'b1;
        wnew = {vl & ~emask, fr & ~emask};
        if (wa32 == pgw32) begin
          if (tgiven) begin
            te            = 1'b1;
            wnew[32 + bp] = 1'b1;
          end
          if (clr_en) cnt_mod = CW'(pg32 + 32'd1);
        end else begin
          mod_done = 1'b0;
          wa_mod   = wa + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      palf_pkg::S_IDLE: begin
        if (in_fire) begin
          if ((in_cmd == palf_pkg::CMD_ALLOC && in_full) ||
              (in_cmd == palf_pkg::CMD_EXTEND && in_ext_bad)) begin
            state_next = palf_pkg::S_DONE;
          end else begin
            state_next = palf_pkg::S_RD;
          end
        end
      end
      palf_pkg::S_RD:   state_next = palf_pkg::S_MOD;
      palf_pkg::S_MOD:  state_next = mod_done ? palf_pkg::S_DONE : palf_pkg::S_RD;
      palf_pkg::S_DONE: begin
        if (!out_valid || m_axis_tready) state_next = palf_pkg::S_IDLE;
      end
      default: state_next = palf_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= palf_pkg::S_IDLE;
      cnt       <= '0;
      nfree     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == palf_pkg::S_MOD) begin
        cnt   <= cnt_mod;
        nfree <= nfree_mod;
      end
      if (state == palf_pkg::S_DONE && (!out_valid || m_axis_tready)) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // command latch, word pointer and result registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd    <= in_cmd;
      pg     <= in_pg;
      tval   <= s_axis_tdata[76:13];
      tgiven <= s_axis_tdata[77];
      mark   <= s_axis_tdata[78];
      grow   <= (nfree == '0);
      if (in_cmd == palf_pkg::CMD_ALLOC) begin
        wa <= (nfree == '0) ? cnt32[5 +: WW] : '0;
      end else if (in_cmd == palf_pkg::CMD_EXTEND && !(in_pg32 < 32'(cnt))) begin
        wa <= cnt32[5 +: WW];
      end else begin
        wa <= in_pg32[5 +: WW];
      end
      res_status <= (in_cmd == palf_pkg::CMD_ALLOC) ? palf_pkg::ST_FULL : palf_pkg::ST_RANGE;
      res_page   <= (in_cmd == palf_pkg::CMD_ALLOC) ? '0 : in_pg;
      res_isa    <= 1'b0;
      res_tag    <= '0;
      res_pres   <= 1'b0;
    end else if (state == palf_pkg::S_MOD) begin
      wa         <= wa_mod;
      res_status <= st_mod;
      res_page   <= page_mod;
      res_isa    <= isa_mod;
      res_tag    <= tag_mod;
      res_pres   <= pres_mod;
    end
    if (state == palf_pkg::S_DONE && (!out_valid || m_axis_tready)) begin
      out_data <= {1'b0, res_pres, res_tag, res_isa, res_page, res_status};
    end
  end

  // bitmap and tag memories: read in S_RD, write back in S_MOD
  always_ff @(posedge clk) begin
    if (state == palf_pkg::S_RD) begin
      wd <= wmem[wa];
      td <= tmem[ti];
    end
    if (state == palf_pkg::S_MOD && we) begin
      wmem[wa] <= wnew;
    end
    if (state == palf_pkg::S_MOD && te) begin
      tmem[ti] <= tval;
    end
  end

`ifndef NO_ASSERTIONS
  // count never passes the pool size
  a_cnt_max: assert property (@(posedge clk) disable iff (rst) 32'(cnt) <= POOL_PAGES)
    else $error("page count beyond pool");
  // free pages are a subset of counted pages
  a_nfree: assert property (@(posedge clk) disable iff (rst) nfree <= cnt)
    else $error("free count exceeds page count");
  // full is only reported with the pool exhausted
  a_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data[2:0] == palf_pkg::ST_FULL) |-> (32'(cnt) == POOL_PAGES))
    else $error("full reported below pool size");
`endif

endmodule
